FILE: rtl/afs_pkg.sv
// Shared types and constants for the animation frame sequencer.
package afs_pkg;

    // Stream and configuration port widths.
    localparam int S_DATA_W   = 64;
    localparam int S_USER_W   = 3;
    localparam int M_DATA_W   = 72;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Progress is a Q0.16 fraction; one whole is carried as a 17-bit value.
    localparam int              FRAC_BITS = 16;
    localparam logic [16:0]     Q16_ONE   = 17'd65536;
    localparam int              PROD_W    = 34;
    localparam logic [PROD_W-1:0] ROUND_HALF = 34'd32768;

    typedef enum logic [1:0] {
        PS_STOPPED,
        PS_PLAYING,
        PS_PAUSED,
        PS_FINISHED
    } t_play_state;

    // Command codes carried in the input tuser.
    localparam logic [2:0] FN_TICK   = 3'd0;
    localparam logic [2:0] FN_PLAY   = 3'd1;
    localparam logic [2:0] FN_PAUSE  = 3'd2;
    localparam logic [2:0] FN_RESUME = 3'd3;
    localparam logic [2:0] FN_STOP   = 3'd4;
    localparam logic [2:0] FN_FINISH = 3'd5;
    localparam logic [2:0] FN_SEEK   = 3'd6;

    // Play modes.
    localparam logic [1:0] MODE_LOOP = 2'd1;
    localparam logic [1:0] MODE_PING = 2'd2;

    // Register indexes.
    localparam logic [2:0] REG_DURATION  = 3'd0;
    localparam logic [2:0] REG_PLAY_MODE = 3'd1;
    localparam logic [2:0] REG_COUNT     = 3'd2;
    localparam logic [2:0] REG_FIRST     = 3'd3;
    localparam logic [2:0] REG_FIXED     = 3'd4;
    localparam logic [2:0] REG_CLAMP     = 3'd5;
    localparam logic [2:0] REG_OVR_EN    = 3'd6;
    localparam logic [2:0] REG_OVR_FRAME = 3'd7;

endpackage

FILE: rtl/afs_divider.sv
// Shared bit-serial restoring divider used for modulo, progress and frame wrap.
module afs_divider #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_start,
    input  logic [$clog2(((TIME_WIDTH > 17) ? TIME_WIDTH : 17) + 1)-1:0] i_steps,
    input  logic [TIME_WIDTH+1:0]                    i_rem,
    input  logic [((TIME_WIDTH > 17) ? TIME_WIDTH : 17)-1:0] i_num,
    input  logic [TIME_WIDTH+1:0]                    i_den,
    output logic                                     o_done,
    output logic [TIME_WIDTH+1:0]                    o_rem,
    output logic [afs_pkg::FRAC_BITS-1:0]            o_quo
);
    import afs_pkg::*;

    localparam int RW = TIME_WIDTH + 2;
    localparam int NW = (TIME_WIDTH > 17) ? TIME_WIDTH : 17;
    localparam int SW = $clog2(NW + 1);

    logic [SW-1:0]        r_cnt;
    logic                 r_done;
    logic [RW-1:0]        r_rem;
    logic [NW-1:0]        r_num;
    logic [RW-1:0]        r_den;
    logic [FRAC_BITS-1:0] r_quo;

    logic [RW-1:0] trial;
    logic [RW-1:0] diff;
    logic          fits;

    // One step: bring in the next numerator bit, subtract when the divisor fits.
    always_comb begin
        trial = {r_rem[RW-2:0], r_num[NW-1]};
        fits  = (trial >= r_den);
        diff  = trial - r_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= i_steps;
                r_rem <= i_rem;
                r_num <= i_num;
                r_den <= i_den;
                r_quo <= '0;
            end else if (r_cnt != '0) begin
                r_rem <= fits ? diff : trial;
                r_num <= r_num << 1;
                r_quo <= {r_quo[FRAC_BITS-2:0], fits};
                r_cnt <= r_cnt - SW'(1);
                if (r_cnt == SW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
    assign o_quo  = r_quo;

endmodule

FILE: rtl/animation_frame_sequencer_unit.sv
// Animation playback sequencer: command decode, end check, progress and frame selection.
// Each item runs through the end check, the cycle position, the fraction and the frame
// selection before its result is registered. A fraction division, an override frame wrap
// and a wrap of the elapsed count each wait on the one shared bit-serial divider.
// Throughput: one item at a time; the next item is taken once its result is in the output
// register. Reset (synchronous, active low) stops playback, clears elapsed and registers.
module animation_frame_sequencer_unit #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Command items.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // tdata, low bit up: delta_ticks[23:0], tick_paused[24], seek_ticks[56:25], zeros.
    input  logic [afs_pkg::S_DATA_W-1:0]    i_s_tdata,
    // tuser: func[2:0].
    input  logic [afs_pkg::S_USER_W-1:0]    i_s_tuser,
    // Result items.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // tdata, low bit up: play_state[1:0], elapsed_out[33:2], progress_q16[50:34],
    // frame_index[67:51], zeros.
    output logic [afs_pkg::M_DATA_W-1:0]    o_m_tdata,
    // Register writes.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [afs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [afs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import afs_pkg::*;

    localparam int TW    = TIME_WIDTH;
    localparam int RW    = TW + 2;
    localparam int NW    = (TW > 17) ? TW : 17;
    localparam int SW    = $clog2(NW + 1);
    localparam int SUM_W = ((TW > 24) ? TW : 24) + 1;
    // Durations and seek targets keep only the bits that the time range holds.
    localparam logic [31:0] DUR_MASK =
        (TW >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << TW) - 64'd1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_END,
        S_EMOD,
        S_PMOD,
        S_PMODW,
        S_FRAC,
        S_FRACW,
        S_FRAME,
        S_MUL,
        S_OVRW,
        S_OUT
    } t_seq_state;

    // Configuration registers.
    logic [31:0] r_duration;
    logic [1:0]  r_mode;
    logic [15:0] r_count;
    logic [15:0] r_first;
    logic        r_fixed;
    logic        r_clamp;
    logic        r_ovr_en;
    logic [16:0] r_ovr_frame;

    // Sequencer state, playback state and working registers.
    t_seq_state         r_state,    n_state;
    t_play_state        r_pstate,   n_pstate;
    logic [TW-1:0]      r_elapsed,  n_elapsed;
    logic               r_run_end,  n_run_end;
    logic [TW-1:0]      r_pos,      n_pos;
    logic               r_invert,   n_invert;
    logic [16:0]        r_progress, n_progress;
    logic [PROD_W-1:0]  r_prod,     n_prod;
    logic [16:0]        r_frame,    n_frame;
    logic               r_out_valid, n_out_valid;
    logic [M_DATA_W-1:0] r_out_data, n_out_data;

    // Shared divider hookup.
    logic          div_start;
    logic [SW-1:0] div_steps;
    logic [RW-1:0] div_rem_init;
    logic [NW-1:0] div_num;
    logic [RW-1:0] div_den;
    logic          div_done;
    logic [RW-1:0] div_rem;
    logic [FRAC_BITS-1:0] div_quo;

    // Command fields.
    logic [23:0] cmd_delta;
    logic        cmd_paused;
    logic [31:0] cmd_seek;

    // Datapath helpers.
    logic [SUM_W-1:0] tick_sum;
    logic [TW-1:0]    tick_el;
    logic [TW-1:0]    dur_t;
    logic [RW-1:0]    dur_ext;
    logic             dur_zero;
    logic             mode_wrap;
    logic             mode_ping;
    logic [RW-1:0]    wrap_den;
    logic             el_ge_den;
    logic [RW-1:0]    pos_ext;
    logic             pos_gt_dur;
    logic [RW-1:0]    frac_num;
    logic             frac_sat;
    logic [16:0]      last_frame;
    logic             ov_low;
    logic             ov_high;
    logic [16:0]      ov_off;
    logic [15:0]      mul_b;
    logic [32:0]      mul_raw;
    logic [PROD_W-1:0] mul_full;
    logic [15:0]      sel;

    assign cmd_delta  = i_s_tdata[23:0];
    assign cmd_paused = i_s_tdata[24];
    assign cmd_seek   = i_s_tdata[56:25];

    // A tick sum that leaves the time range saturates at its top.
    assign tick_sum = SUM_W'(r_elapsed) + SUM_W'(cmd_delta);
    assign tick_el  = (|tick_sum[SUM_W-1:TW]) ? '1 : tick_sum[TW-1:0];

    assign dur_t     = TW'(r_duration);
    assign dur_ext   = RW'(r_duration);
    assign dur_zero  = (r_duration == '0);
    assign mode_ping = (r_mode == MODE_PING);
    assign mode_wrap = (r_mode == MODE_LOOP) || mode_ping;
    // Loop wraps at the duration, ping-pong at twice the duration.
    assign wrap_den  = mode_ping ? (dur_ext << 1) : dur_ext;
    assign el_ge_den = (RW'(r_elapsed) >= wrap_den);

    // In the returning half of a ping-pong cycle the fraction is mirrored.
    assign pos_ext    = RW'(r_pos);
    assign pos_gt_dur = mode_ping && (pos_ext > dur_ext);
    assign frac_num   = pos_gt_dur ? (pos_ext - dur_ext) : pos_ext;
    assign frac_sat   = (frac_num >= dur_ext);

    assign last_frame = 17'(r_first) + 17'(r_count) - 17'd1;
    assign ov_low     = (r_ovr_frame < 17'(r_first));
    assign ov_high    = (r_ovr_frame > last_frame);
    assign ov_off     = r_ovr_frame - 17'(r_first);

    // Floor selection scales by the count; rounding selection by count minus one.
    assign mul_b    = r_fixed ? r_count : (r_count - 16'd1);
    assign mul_raw  = 33'(r_progress) * 33'(mul_b);
    assign mul_full = PROD_W'(mul_raw) + (r_fixed ? '0 : ROUND_HALF);
    assign sel      = (r_fixed && (r_prod[31:16] >= r_count)) ? (r_count - 16'd1)
                                                              : r_prod[31:16];

    always_comb begin
        n_state      = r_state;
        n_pstate     = r_pstate;
        n_elapsed    = r_elapsed;
        n_run_end    = r_run_end;
        n_pos        = r_pos;
        n_invert     = r_invert;
        n_progress   = r_progress;
        n_prod       = r_prod;
        n_frame      = r_frame;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        div_start    = 1'b0;
        div_steps    = SW'(TW);
        div_rem_init = '0;
        div_num      = NW'(r_elapsed) << (NW - TW);
        div_den      = wrap_den;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_run_end = 1'b0;
                    n_state   = S_END;
                    case (i_s_tuser)
                        FN_TICK: begin
                            if (!cmd_paused && (r_pstate == PS_PLAYING) &&
                                (cmd_delta != '0)) begin
                                n_elapsed = tick_el;
                                n_run_end = 1'b1;
                            end
                        end
                        FN_PLAY: begin
                            if (r_pstate == PS_FINISHED) begin
                                n_elapsed = '0;
                            end
                            n_pstate  = PS_PLAYING;
                            n_run_end = 1'b1;
                        end
                        FN_PAUSE: begin
                            if (r_pstate == PS_PLAYING) begin
                                n_pstate = PS_PAUSED;
                            end
                        end
                        FN_RESUME: begin
                            if (r_pstate == PS_PAUSED) begin
                                n_pstate = PS_PLAYING;
                            end
                        end
                        FN_STOP: begin
                            n_elapsed = '0;
                            n_pstate  = PS_STOPPED;
                        end
                        FN_FINISH: begin
                            n_elapsed = dur_t;
                            n_pstate  = PS_FINISHED;
                        end
                        FN_SEEK: begin
                            n_elapsed = TW'(cmd_seek & DUR_MASK);
                            n_run_end = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // End check after a tick, play or seek: finish on zero duration, wrap in loop and ping-pong,
            // clamp and finish in once mode; only a playing animation is finished.
            S_END: begin
                n_state = S_PMOD;
                if (r_run_end) begin
                    if (dur_zero) begin
                        if (r_pstate == PS_PLAYING) begin
                            n_pstate = PS_FINISHED;
                        end
                    end else if (mode_wrap) begin
                        if (el_ge_den) begin
                            div_start = 1'b1;
                            n_state   = S_EMOD;
                        end
                    end else if (RW'(r_elapsed) >= dur_ext) begin
                        n_elapsed = dur_t;
                        if (r_pstate == PS_PLAYING) begin
                            n_pstate = PS_FINISHED;
                        end
                    end
                end
            end

            S_EMOD: begin
                if (div_done) begin
                    n_elapsed = div_rem[TW-1:0];
                    n_state   = S_PMOD;
                end
            end

            // Position within the cycle; the elapsed count itself is left alone.
            S_PMOD: begin
                n_pos = r_elapsed;
                if (dur_zero) begin
                    n_progress = ((r_elapsed != '0) || (r_pstate == PS_FINISHED)) ?
                                 Q16_ONE : '0;
                    n_state    = S_FRAME;
                end else if (mode_wrap && el_ge_den) begin
                    div_start = 1'b1;
                    n_state   = S_PMODW;
                end else begin
                    n_state = S_FRAC;
                end
            end

            S_PMODW: begin
                if (div_done) begin
                    n_pos   = div_rem[TW-1:0];
                    n_state = S_FRAC;
                end
            end

            S_FRAC: begin
                n_invert = pos_gt_dur;
                if (frac_sat) begin
                    n_progress = pos_gt_dur ? '0 : Q16_ONE;
                    n_state    = S_FRAME;
                end else begin
                    div_start    = 1'b1;
                    div_steps    = SW'(FRAC_BITS);
                    div_rem_init = frac_num;
                    div_num      = '0;
                    div_den      = dur_ext;
                    n_state      = S_FRACW;
                end
            end

            S_FRACW: begin
                if (div_done) begin
                    n_progress = r_invert ? (Q16_ONE - 17'(div_quo)) : 17'(div_quo);
                    n_state    = S_FRAME;
                end
            end

            S_FRAME: begin
                n_state = S_OUT;
                if (r_count == '0) begin
                    n_frame = 17'(r_first);
                end else if (r_ovr_en) begin
                    if (ov_low) begin
                        n_frame = 17'(r_first);
                    end else if (ov_high && r_clamp) begin
                        n_frame = last_frame;
                    end else if (ov_high) begin
                        div_start    = 1'b1;
                        div_steps    = SW'(17);
                        div_rem_init = '0;
                        div_num      = NW'(ov_off) << (NW - 17);
                        div_den      = RW'(r_count);
                        n_state      = S_OVRW;
                    end else begin
                        n_frame = r_ovr_frame;
                    end
                end else begin
                    n_prod  = mul_full;
                    n_state = S_MUL;
                end
            end

            S_MUL: begin
                n_frame = 17'(r_first) + 17'(sel);
                n_state = S_OUT;
            end

            S_OVRW: begin
                if (div_done) begin
                    n_frame = 17'(r_first) + 17'(div_rem[15:0]);
                    n_state = S_OUT;
                end
            end

            // Load the output register once it is free or being emptied.
            S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {4'b0, r_frame, r_progress, 32'(r_elapsed), r_pstate};
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pstate    <= PS_STOPPED;
            r_elapsed   <= '0;
            r_run_end   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pstate    <= n_pstate;
            r_elapsed   <= n_elapsed;
            r_run_end   <= n_run_end;
            r_out_valid <= n_out_valid;
        end
        r_pos      <= n_pos;
        r_invert   <= n_invert;
        r_progress <= n_progress;
        r_prod     <= n_prod;
        r_frame    <= n_frame;
        r_out_data <= n_out_data;
    end

    // Register writes are always accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration  <= '0;
            r_mode      <= '0;
            r_count     <= '0;
            r_first     <= '0;
            r_fixed     <= 1'b0;
            r_clamp     <= 1'b0;
            r_ovr_en    <= 1'b0;
            r_ovr_frame <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DURATION:  r_duration  <= i_cfg_data & DUR_MASK;
                REG_PLAY_MODE: r_mode      <= i_cfg_data[1:0];
                REG_COUNT:     r_count     <= i_cfg_data[15:0];
                REG_FIRST:     r_first     <= i_cfg_data[15:0];
                REG_FIXED:     r_fixed     <= i_cfg_data[0];
                REG_CLAMP:     r_clamp     <= i_cfg_data[0];
                REG_OVR_EN:    r_ovr_en    <= i_cfg_data[0];
                REG_OVR_FRAME: r_ovr_frame <= i_cfg_data[16:0];
                default: begin
                end
            endcase
        end
    end

    afs_divider #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_steps (div_steps),
        .i_rem   (div_rem_init),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_rem   (div_rem),
        .o_quo   (div_quo)
    );

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_cfg_ready = 1'b1;

    // An accepted item keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input ready right after an accepted item");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_EMOD || r_state == S_PMODW ||
                      r_state == S_FRACW || r_state == S_OVRW))
        else $error("divider finished outside a wait state");

    // Reported progress never exceeds one whole.
    a_progress_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[50:34] <= Q16_ONE))
        else $error("progress above one");

endmodule
